[hdl/ictf_pkg.sv]
// Package for the complementary tilt filter core: widths, register indexes,
// CORDIC arctangent table. No dependencies.
package ictf_pkg;

    localparam int ANG_W = 32;
    localparam int CW    = 36;   // CORDIC datapath width

    typedef enum logic [2:0] {
        REG_GYRO_GAIN = 3'd0,
        REG_ALPHA     = 3'd1,
        REG_MAX_NORM  = 3'd2,
        REG_FLIP_X    = 3'd3,
        REG_FLIP_Y    = 3'd4
    } t_reg_idx;

    // one CORDIC working set handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:  v = 36'sd2949120;
            5'd1:  v = 36'sd1740967;
            5'd2:  v = 36'sd919879;
            5'd3:  v = 36'sd466945;
            5'd4:  v = 36'sd234379;
            5'd5:  v = 36'sd117304;
            5'd6:  v = 36'sd58666;
            5'd7:  v = 36'sd29335;
            5'd8:  v = 36'sd14668;
            5'd9:  v = 36'sd7334;
            5'd10: v = 36'sd3667;
            5'd11: v = 36'sd1833;
            5'd12: v = 36'sd917;
            5'd13: v = 36'sd458;
            5'd14: v = 36'sd229;
            5'd15: v = 36'sd115;
            5'd16: v = 36'sd57;
            5'd17: v = 36'sd29;
            5'd18: v = 36'sd14;
            5'd19: v = 36'sd7;
            5'd20: v = 36'sd4;
            5'd21: v = 36'sd2;
            5'd22: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[ANG_W-1:0];
    endfunction

endpackage

[hdl/ictf_cordic_cell.sv]
// One vectoring CORDIC cell with a fixed shift; registered output.
// Depends on ictf_pkg.
module ictf_cordic_cell
    import ictf_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_d,
    output t_cordic o_d
);
    t_cordic n_d, r_d;

    // arithmetic shift is a floor shift
    always_comb begin
        n_d = i_d;
        if (!i_d.y[CW-1]) begin
            n_d.x = i_d.x + (i_d.y >>> STEP);
            n_d.y = i_d.y - (i_d.x >>> STEP);
            n_d.z = i_d.z + atan_entry(5'(STEP));
        end else begin
            n_d.x = i_d.x - (i_d.y >>> STEP);
            n_d.y = i_d.y + (i_d.x >>> STEP);
            n_d.z = i_d.z - atan_entry(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

[hdl/ictf_cordic_chain.sv]
// Row of CORDIC cells computing atan2(num, den) in Q16.16 degrees.
// Depends on ictf_pkg and ictf_cordic_cell.
module ictf_cordic_chain
    import ictf_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [15:0]      i_num,
    input  logic signed [15:0]      i_den,
    output logic signed [ANG_W-1:0] o_angle
);
    localparam int NC = (STEPS > 32) ? 32 : STEPS;

    t_cordic c_d [NC+1];
    t_cordic s_pre;
    logic    r_zero [NC+1];
    logic signed [CW-1:0] w_x, w_y;

    assign w_x = CW'(i_den) <<< 14;
    assign w_y = CW'(i_num) <<< 14;

    // quarter-turn pre-rotation for the left half plane
    always_comb begin
        s_pre.x = w_x;
        s_pre.y = w_y;
        s_pre.z = '0;
        if (w_x[CW-1]) begin
            if (!w_y[CW-1]) begin
                s_pre.x = w_y;
                s_pre.y = -w_x;
                s_pre.z = CW'(90 * 65536);
            end else begin
                s_pre.x = -w_y;
                s_pre.y = w_x;
                s_pre.z = -CW'(90 * 65536);
            end
        end
    end

    assign c_d[0]  = s_pre;
    assign r_zero[0] = (i_num == 16'sd0) && (i_den == 16'sd0);

    for (genvar g = 0; g < NC; g++) begin : g_cell
        ictf_cordic_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_en(i_en), .i_d(c_d[g]), .o_d(c_d[g+1])
        );
        logic r_z;
        always_ff @(posedge i_clk) begin
            if (i_en) r_z <= r_zero[g];
        end
        assign r_zero[g+1] = r_z;
    end

    assign o_angle = r_zero[NC] ? '0 : c_d[NC].z[ANG_W-1:0];
endmodule

[hdl/imu_complementary_tilt_filter_core.sv]
// Complementary tilt filter core: gyro integration, accelerometer tilt blend.
// A request passes the gyro, CORDIC, blend and output states in turn before o_valid
// (CORDIC step count capped at 32); one request at a time, a new one only once the
// result is out; the CORDIC cell row sets most of the latency. An untaken result stalls.
// Synchronous active-low reset clears angles, zero point, registers to defaults.
// Depends on ictf_pkg, ictf_cordic_chain.
module imu_complementary_tilt_filter_core
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [15:0]      i_accel_x,
    input  logic signed [15:0]      i_accel_y,
    input  logic signed [15:0]      i_accel_z,
    input  logic signed [15:0]      i_rate_x,
    input  logic signed [15:0]      i_rate_y,
    input  logic signed [15:0]      i_rate_z,
    input  logic                    i_mode,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [ANG_W-1:0] o_pitch,
    output logic signed [ANG_W-1:0] o_roll,
    output logic signed [ANG_W-1:0] o_yaw,
    output logic                    o_accel_used,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);
    localparam int NC    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CNT_W = $clog2(NC + 4);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_GYRO  = 5'b00010,
        S_CORD  = 5'b00100,
        S_BLEND = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;

    // configuration registers
    logic [15:0] r_gain;
    logic [16:0] r_alpha;
    logic [31:0] r_max_norm;
    logic        r_flip_x, r_flip_y;

    // state
    logic signed [ANG_W-1:0] r_acc_x, r_acc_y, r_acc_z, r_zero_x, r_zero_y, r_zero_z;

    // captured request
    logic signed [15:0] r_ax, r_ay, r_az, r_rx, r_ry, r_rz;
    logic               r_mode, r_used;
    logic signed [47:0] r_px, r_py;   // blend partial products
    logic [33:0]        r_norm;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= 16'd1;
            r_alpha    <= 17'd1311;
            r_max_norm <= 32'd3221225472;
            r_flip_x   <= 1'b0;
            r_flip_y   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GYRO_GAIN: r_gain     <= i_cfg_data[15:0];
                REG_ALPHA:     r_alpha    <= i_cfg_data[16:0];
                REG_MAX_NORM:  r_max_norm <= i_cfg_data;
                REG_FLIP_X:    r_flip_x   <= i_cfg_data[0];
                REG_FLIP_Y:    r_flip_y   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // tilt angles: two rows of CORDIC cells, advanced while computing
    logic signed [ANG_W-1:0] w_tx, w_ty;
    logic w_cen;
    assign w_cen = (r_state == S_CORD);

    ictf_cordic_chain #(.STEPS(NC)) u_tx (
        .i_clk(i_clk), .i_en(w_cen), .i_num(r_ay), .i_den(r_az), .o_angle(w_tx)
    );
    ictf_cordic_chain #(.STEPS(NC)) u_ty (
        .i_clk(i_clk), .i_en(w_cen), .i_num(r_ax), .i_den(r_az), .o_angle(w_ty)
    );

    logic [16:0] w_a;
    logic signed [ANG_W-1:0] w_tx_f, w_ty_f;
    assign w_a    = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;
    assign w_tx_f = r_flip_x ? -w_tx : w_tx;
    assign w_ty_f = r_flip_y ? -w_ty : w_ty;

    // blend: one multiply per term per axis
    function automatic logic signed [ANG_W-1:0] blend_fin(
        input logic signed [47:0] p_acc, input logic signed [47:0] p_tilt);
        logic signed [63:0] s;
        s = 64'(p_acc) + 64'(p_tilt) + 64'sd32768;
        return sat32(s >>> 16);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            o_valid  <= 1'b0;
            r_acc_x  <= '0; r_acc_y <= '0; r_acc_z <= '0;
            r_zero_x <= '0; r_zero_y <= '0; r_zero_z <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ax <= i_accel_x; r_ay <= i_accel_y; r_az <= i_accel_z;
                        r_rx <= i_rate_x;  r_ry <= i_rate_y;  r_rz <= i_rate_z;
                        r_mode  <= i_mode;
                        r_state <= S_GYRO;
                    end
                end
                S_GYRO: begin
                    r_acc_x <= sat32(64'(r_acc_x) + 64'(r_rx * $signed({1'b0, r_gain})));
                    r_acc_y <= sat32(64'(r_acc_y) + 64'(r_ry * $signed({1'b0, r_gain})));
                    r_acc_z <= sat32(64'(r_acc_z) + 64'(r_rz * $signed({1'b0, r_gain})));
                    r_norm  <= 34'(32'(r_ax * r_ax)) + 34'(32'(r_ay * r_ay))
                             + 34'(32'(r_az * r_az));
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_used <= (r_norm < 34'(r_max_norm));
                    // the cell rows stay enabled until r_cnt reaches NC; their inputs hold steady meanwhile
                    if (r_cnt == CNT_W'(NC)) begin
                        r_px    <= 48'(r_acc_x * $signed({1'b0, 17'd65536 - w_a}));
                        r_py    <= 48'(r_acc_y * $signed({1'b0, 17'd65536 - w_a}));
                        r_state <= S_BLEND;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_BLEND: begin
                    if (r_used) begin
                        r_acc_x <= blend_fin(r_px, 48'(w_tx_f * $signed({1'b0, w_a})));
                        r_acc_y <= blend_fin(r_py, 48'(w_ty_f * $signed({1'b0, w_a})));
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_pitch      <= sat32(64'(r_acc_x) - 64'(r_zero_x));
                        o_roll       <= sat32(64'(r_acc_y) - 64'(r_zero_y));
                        o_yaw        <= sat32(64'(r_acc_z) - 64'(r_zero_z));
                        o_accel_used <= r_used;
                        o_valid      <= 1'b1;
                        if (r_mode) begin
                            r_zero_x <= r_acc_x; r_zero_y <= r_acc_y; r_zero_z <= r_acc_z;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end
endmodule

[tb/tilt_filter_checker.sv]
// Checker for the complementary tilt filter core: mirrors the register file,
// predicts each result from accepted requests, compares field by field.
// Depends on ictf_pkg.
`timescale 1ns / 1ps
module tilt_filter_checker
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_ready_in,
    input  logic signed [15:0]      i_accel_x,
    input  logic signed [15:0]      i_accel_y,
    input  logic signed [15:0]      i_accel_z,
    input  logic signed [15:0]      i_rate_x,
    input  logic signed [15:0]      i_rate_y,
    input  logic signed [15:0]      i_rate_z,
    input  logic                    i_mode,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [ANG_W-1:0] i_pitch,
    input  logic signed [ANG_W-1:0] i_roll,
    input  logic signed [ANG_W-1:0] i_yaw,
    input  logic                    i_accel_used,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [31:0] yaw;
        logic               used;
    } t_angles;

    t_angles angle_q[$];

    longint gain, alpha, norm_max;
    bit     neg_x, neg_y;
    longint acc_x, acc_y, acc_z, zx, zy, zz;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint tab(int i);
        case (i)
            0: return 2949120;   1: return 1740967;  2: return 919879;
            3: return 466945;    4: return 234379;   5: return 117304;
            6: return 58666;     7: return 29335;    8: return 14668;
            9: return 7334;      10: return 3667;    11: return 1833;
            12: return 917;      13: return 458;     14: return 229;
            15: return 115;      16: return 57;      17: return 29;
            18: return 14;       19: return 7;       20: return 4;
            21: return 2;        22: return 1;
            default: return 0;
        endcase
    endfunction

    // atan2(num, den) in Q16.16 degrees, vectoring mode
    function automatic longint atan2_deg(longint num, longint den);
        longint x, y, z, nx, dx, dy;
        int n;
        z = 0;
        if (num == 0 && den == 0) return 0;
        x = den * 16384;
        y = num * 16384;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; y = -x; z = 90 * 65536;
            end else begin
                nx = -y; y = x; z = -90 * 65536;
            end
            x = nx;
        end
        n = CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
        for (int i = 0; i < n; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += tab(i);
            end else begin
                x -= dx; y += dy; z -= tab(i);
            end
        end
        return z;
    endfunction

    function automatic longint mix(longint acc, longint tilt, longint a);
        return clamp32(fshr(acc * (65536 - a) + tilt * a + 32768, 16));
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    task automatic predict_angles();
        longint ax, ay, az, a, tx, ty;
        t_angles r;
        ax = longint'(i_accel_x); ay = longint'(i_accel_y); az = longint'(i_accel_z);
        acc_x = clamp32(acc_x + longint'(i_rate_x) * gain);
        acc_y = clamp32(acc_y + longint'(i_rate_y) * gain);
        acc_z = clamp32(acc_z + longint'(i_rate_z) * gain);
        r.used = (ax * ax + ay * ay + az * az) < norm_max;
        if (r.used) begin
            a = alpha > 65536 ? 65536 : alpha;
            tx = atan2_deg(ay, az);
            ty = atan2_deg(ax, az);
            if (neg_x) tx = -tx;
            if (neg_y) ty = -ty;
            acc_x = mix(acc_x, tx, a);
            acc_y = mix(acc_y, ty, a);
        end
        r.pitch = 32'(clamp32(acc_x - zx));
        r.roll  = 32'(clamp32(acc_y - zy));
        r.yaw   = 32'(clamp32(acc_z - zz));
        angle_q.push_back(r);
        if (i_mode) begin
            zx = acc_x; zy = acc_y; zz = acc_z;
        end
    endtask

    always @(posedge i_clk) begin
        t_angles e;
        if (!i_rst_n) begin
            gain = 1; alpha = 1311; norm_max = 64'd3221225472;
            neg_x = 0; neg_y = 0;
            acc_x = 0; acc_y = 0; acc_z = 0; zx = 0; zy = 0; zz = 0;
            angle_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_GYRO_GAIN: gain = longint'(i_cfg_data[15:0]);
                    REG_ALPHA:     alpha = longint'(i_cfg_data[16:0]);
                    REG_MAX_NORM:  norm_max = longint'(i_cfg_data);
                    REG_FLIP_X:    neg_x = i_cfg_data[0];
                    REG_FLIP_Y:    neg_y = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (angle_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    e = angle_q.pop_front();
                    if (i_pitch !== e.pitch) report("pitch", i_pitch, e.pitch);
                    if (i_roll !== e.roll) report("roll", i_roll, e.roll);
                    if (i_yaw !== e.yaw) report("yaw", i_yaw, e.yaw);
                    if (i_accel_used !== e.used) report("accel_used", i_accel_used, e.used);
                end
            end
            if (i_valid && i_ready_in) predict_angles();
        end
        o_pending = angle_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

[tb/tb.sv]
// Top of the tilt filter testbench: clock, reset, stimulus, verdict.
// Depends on ictf_pkg, imu_complementary_tilt_filter_core, tilt_filter_checker.
`timescale 1ns / 1ps
module tb;
    import ictf_pkg::*;

    localparam int STEPS   = 16;
    localparam int LAT     = STEPS + 4;
    localparam int RAND_N  = 450;
    localparam longint LIMIT = 1_000_000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [15:0]      ax, ay, az, rx, ry, rz;
    logic                    mode;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [ANG_W-1:0] pitch, roll, yaw;
    logic                    accel_used;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [31:0]             cfg_data;
    int                      errors;
    int                      pending;
    longint                  cycles;

    imu_complementary_tilt_filter_core #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .i_rate_x(rx), .i_rate_y(ry), .i_rate_z(rz), .i_mode(mode),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_pitch(pitch), .o_roll(roll), .o_yaw(yaw), .o_accel_used(accel_used),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tilt_filter_checker #(.CORDIC_STEPS(STEPS)) chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .i_rate_x(rx), .i_rate_y(ry), .i_rate_z(rz), .i_mode(mode),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_pitch(pitch), .i_roll(roll), .i_yaw(yaw), .i_accel_used(accel_used),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Watchdog; the slowest run (450+ requests) is well under this.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stall: random backpressure, with quiet stretches of always-ready.
    initial begin
        int quiet;
        out_ready = 0;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (quiet > 0) begin
                quiet--;
                out_ready <= 1;
            end else if ($urandom_range(0, 99) < 3) begin
                quiet = $urandom_range(50, 300);
                out_ready <= 1;
            end else begin
                out_ready <= (gap_len() == 0);
            end
        end
    end

    // Valid drops between requests; the core is busy right after it takes one.
    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, logic signed [15:0] gx,
                               logic signed [15:0] gy, logic signed [15:0] gz,
                               logic m, bit hold);
        int g;
        g = hold ? gap_len() : 0;
        repeat (g + 1) @(posedge clk);
        in_valid <= 1;
        ax <= x; ay <= y; az <= z; rx <= gx; ry <= gy; rz <= gz; mode <= m;
        do @(posedge clk); while (!in_ready);
        in_valid <= 0;
    endtask

    task automatic rand_sample(bit hold);
        logic signed [15:0] v[6];
        int shape;
        shape = $urandom_range(0, 9);
        foreach (v[k]) v[k] = 16'($urandom);
        // Mostly gravity-like accel magnitudes so the blend path runs often
        if (shape < 6) begin
            v[0] = $signed(16'($urandom)) >>> $urandom_range(1, 4);
            v[1] = $signed(16'($urandom)) >>> $urandom_range(1, 4);
            v[2] = $signed(16'($urandom)) >>> $urandom_range(1, 4);
            v[3] = $signed(16'($urandom)) >>> $urandom_range(0, 12);
            v[4] = $signed(16'($urandom)) >>> $urandom_range(0, 12);
            v[5] = $signed(16'($urandom)) >>> $urandom_range(0, 12);
        end else if (shape == 6) begin
            v[$urandom_range(0, 2)] = 0;
        end
        send_sample(v[0], v[1], v[2], v[3], v[4], v[5],
                    ($urandom_range(0, 15) == 0), hold);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // The checker counts a request at the clock edge on which it is taken.
    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    initial begin
        logic [31:0] gains[4];
        logic [31:0] alphas[4];
        logic [31:0] norms[4];
        rst_n = 0; in_valid = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        ax = 0; ay = 0; az = 0; rx = 0; ry = 0; rz = 0; mode = 0;
        cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset settings first, axis extremes, origin, zero capture.
        send_sample(0, 0, 0, 0, 0, 0, 0, 0);                 // both atan2 operands zero
        send_sample(0, 0, 16384, 100, -100, 5, 0, 0);
        send_sample(16384, 16384, -16384, 1, 1, 1, 0, 0);    // negative z, +90 pre-rotation
        send_sample(-16384, -16384, -16384, 1, 1, 1, 0, 0);  // negative z, -90 pre-rotation
        send_sample(0, 0, -16384, 0, 0, 0, 0, 0);
        send_sample(-32768, 32767, -32768, 0, 0, 0, 0, 0);   // norm just below the default threshold
        send_sample(100, -100, 0, 0, 0, 0, 1, 0);            // zero capture
        send_sample(100, -100, 0, 7, 7, 7, 0, 0);
        wait_idle();

        // Big gain plus extreme rates drives the accumulators into saturation.
        write_reg(REG_GYRO_GAIN, 32'd65535);
        write_reg(REG_ALPHA, 32'd65536);
        write_reg(REG_MAX_NORM, 32'd0);
        write_reg(REG_FLIP_X, 32'd1);
        write_reg(REG_FLIP_Y, 32'd1);
        repeat (3) send_sample(1, 2, 3, 32767, 32767, 32767, 0, 0);
        send_sample(0, 0, 0, -32768, -32768, -32768, 1, 0);
        repeat (3) send_sample(0, 0, 0, -32768, -32768, -32768, 0, 0);
        send_sample(0, 0, 0, 32767, 32767, 32767, 0, 0);
        wait_idle();
        write_reg(REG_MAX_NORM, 32'hFFFF_FFFF);
        write_reg(REG_ALPHA, 32'h1FFFF);                     // above one, clamps
        send_sample(1000, -1000, 16000, 0, 0, 0, 0, 0);
        send_sample(-32768, -32768, -32768, 0, 0, 0, 0, 0);
        send_sample(32767, 32767, 32767, 0, 0, 0, 0, 0);
        wait_idle();

        // Random phases over several settings.
        gains  = '{0, 1, 300, 65535};
        alphas = '{0, 1311, 40000, 65536};
        norms  = '{32'd0, 32'd268435456, 32'd3221225472, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_GYRO_GAIN, (ph < 4) ? gains[ph] : $urandom_range(0, 65535));
            write_reg(REG_ALPHA, (ph < 4) ? alphas[ph] : $urandom_range(0, 65536));
            write_reg(REG_MAX_NORM, norms[$urandom_range(1, 3)]);
            write_reg(REG_FLIP_X, 32'(ph[0]));
            write_reg(REG_FLIP_Y, 32'(ph[1]));
            for (int n = 0; n < RAND_N / 6; n++) rand_sample(1);
            wait_idle();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hdl/ictf_pkg.sv
hdl/ictf_cordic_cell.sv
hdl/ictf_cordic_chain.sv
hdl/imu_complementary_tilt_filter_core.sv
tb/tilt_filter_checker.sv
tb/tb.sv
